// ===== hdl/ppt_pkg.sv =====
// Shared types, constants and tables for the phasor period tracker.
// No dependencies; every other file but ppt_fifo.sv imports this package.
`timescale 1ns / 1ps
package ppt_pkg;

	localparam int SAMPLE_BITS_DEF  = 16;
	localparam int CORDIC_STEPS_DEF = 24;
	localparam int QUEUE_DEPTH_DEF  = 2;

	// reciprocal of the CORDIC gain, Q0.32
	localparam logic [31:0] INV_GAIN = 32'd2608131497;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_INV_PERIOD   = 2'd0;
	localparam logic [1:0] REG_PHASE_OFFSET = 2'd1;
	localparam logic [1:0] REG_GAIN         = 2'd2;

	// per-item facts worked out at acceptance
	typedef struct packed {
		logic [47:0] t;        // Q32.16 time with offset, low 48 bits
		logic        first;    // no earlier item
		logic        dur_pos;  // duration known and above zero
		logic [31:0] dur;
	} ppt_meta_t;

	typedef struct packed {
		logic        start;
		logic [50:0] rem_init;
		logic [47:0] dividend;
		logic [49:0] divisor;
		logic [5:0]  steps;
	} ppt_div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [47:0] quot;
	} ppt_div_rsp_t;

	typedef struct packed {
		logic idle;
		logic out_wait;
	} ppt_back_stat_t;

	// arctangent of 2^-k in Q0.32 turns
	function automatic logic [31:0] atan_turns(input logic [4:0] k);
		logic [31:0] r;
		unique case (k)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// clamp to 40-bit signed
	function automatic logic signed [39:0] sat40(input logic signed [45:0] v);
		logic signed [39:0] r;
		if (v > 46'sd549755813887)
			r = 40'sh7F_FFFF_FFFF;
		else if (v < -46'sd549755813888)
			r = 40'sh80_0000_0000;
		else
			r = v[39:0];
		return r;
	endfunction

endpackage

// ===== hdl/ppt_fifo.sv =====
// Short item queue between the front and the back of the tracker.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module ppt_fifo #(
	parameter int W     = 98,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         full,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign full  = (count_q == CNTW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end
endmodule

// ===== hdl/ppt_front.sv =====
// Input side: accept samples, form the mixer time and classify the duration.
// Depends on ppt_pkg.
`timescale 1ns / 1ps
module ppt_front #(
	parameter int SAMPLE_BITS = ppt_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [47:0]            s_tdata,
	input  logic [31:0]            phase_offset,
	input  logic                   q_full,
	output logic                   push,
	output logic [SAMPLE_BITS-1:0] push_sample,
	output ppt_pkg::ppt_meta_t     push_meta
);
	import ppt_pkg::*;

	logic [31:0] now, prior_time_q;
	logic [23:0] sv_ext;
	logic [32:0] diff;
	logic        seen_first_q;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;
	assign now      = s_tdata[31:0];
	assign sv_ext   = {8'b0, s_tdata[47:32]};
	assign diff     = {1'b0, now} - {1'b0, prior_time_q};

	always_comb begin
		push_sample       = sv_ext[SAMPLE_BITS-1:0];
		push_meta.t       = {now, 16'b0} + 48'($signed(phase_offset));
		push_meta.first   = !seen_first_q;
		push_meta.dur_pos = seen_first_q && !diff[32] && (diff != '0);
		push_meta.dur     = diff[31:0];
	end

	// hold the previous sample time for the next duration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_time_q <= '0;
			seen_first_q <= 1'b0;
		end else if (push) begin
			prior_time_q <= now;
			seen_first_q <= 1'b1;
		end
	end
endmodule

// ===== hdl/ppt_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Depends on ppt_pkg.
`timescale 1ns / 1ps
module ppt_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ppt_pkg::ppt_div_req_t req,
	output ppt_pkg::ppt_div_rsp_t rsp
);
	import ppt_pkg::*;

	logic [50:0] rem_q;
	logic [47:0] d_q, quot_q;
	logic [49:0] div_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [51:0] rem2, rem_sub;
	logic        ge;

	assign rem2    = {rem_q, d_q[47]};
	assign rem_sub = rem2 - {2'b0, div_q};
	assign ge      = (rem2 >= {2'b0, div_q});

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			d_q    <= '0;
			div_q  <= '0;
			quot_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			rem_q  <= req.rem_init;
			d_q    <= req.dividend;
			div_q  <= req.divisor;
			cnt_q  <= req.steps;
			quot_q <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q  <= ge ? rem_sub[50:0] : rem2[50:0];
			d_q    <= {d_q[46:0], 1'b0};
			quot_q <= {quot_q[46:0], ge};
			cnt_q  <= cnt_q - 1'b1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end
endmodule

// ===== hdl/ppt_back.sv =====
// Back end: mixer, smoother, vectoring, phase step and period, plus the output register.
// Depends on ppt_pkg; uses the shared divider through its request port.
`timescale 1ns / 1ps
module ppt_back #(
	parameter int SAMPLE_BITS  = ppt_pkg::SAMPLE_BITS_DEF,
	parameter int CORDIC_STEPS = ppt_pkg::CORDIC_STEPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  logic [SAMPLE_BITS-1:0]  head_sample,
	input  ppt_pkg::ppt_meta_t      head_meta,
	output logic                    q_pop,
	input  logic [31:0]             inverse_period,
	input  logic [23:0]             smoothing_gain,
	output ppt_pkg::ppt_div_req_t   div_req,
	input  ppt_pkg::ppt_div_rsp_t   div_rsp,
	output ppt_pkg::ppt_back_stat_t stat,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [111:0]            m_tdata
);
	import ppt_pkg::*;

	localparam int CW  = SAMPLE_BITS + 34;
	localparam int IW  = $clog2(CORDIC_STEPS);
	localparam int PSH = SAMPLE_BITS - 8;
	localparam int MSH = 24 - SAMPLE_BITS;
	localparam logic [5:0]  DIV_Q_STEPS = 6'd48;
	localparam logic [5:0]  DIV_P_STEPS = 6'd32;
	localparam logic [31:0] PERIOD_MAX  = 32'h7FFF_FFFF;
	localparam logic [31:0] PERIOD_MIN  = 32'h8000_0000;

	typedef enum logic [21:0] {
		S_IDLE = 22'h000001, S_TH0  = 22'h000002, S_TH1  = 22'h000004,
		S_TH2  = 22'h000008, S_X0   = 22'h000010, S_ROT  = 22'h000020,
		S_SH   = 22'h000040, S_G0   = 22'h000080, S_G1   = 22'h000100,
		S_G2   = 22'h000200, S_G3   = 22'h000400, S_G4   = 22'h000800,
		S_VEC0 = 22'h001000, S_VEC  = 22'h002000, S_M0   = 22'h004000,
		S_M1   = 22'h008000, S_M2   = 22'h010000, S_STEP = 22'h020000,
		S_QDIV = 22'h040000, S_F    = 22'h080000, S_PDIV = 22'h100000,
		S_OUT  = 22'h200000
	} state_t;

	state_t state_q;

	logic [47:0]                   t_q;
	logic signed [SAMPLE_BITS-1:0] samp_q;
	logic                          first_q, dur_pos_q, fneg_q;
	logic [31:0]                   dur_q, theta_q, mag_q, per_q;
	logic signed [CW-1:0]          x_q, y_q;
	logic signed [33:0]            z_q;
	logic [IW-1:0]                 i_q;
	logic [41:0]                   dr_q, di_q;
	logic signed [43:0]            gr_q;
	logic signed [39:0]            acc_re_q, acc_im_q;
	logic [58:0]                   mh_q;
	logic [23:0]                   phase_q, prior_phase_q, step_q;
	logic                          nz_q, prior_nz_q;
	logic signed [48:0]            q_q;
	logic                          out_valid_q;
	logic [111:0]                  out_data_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mprod_q;

	logic signed [CW-1:0] sh_x, sh_y, nx, ny, xv, px, py;
	logic signed [33:0]   at, nz;
	logic                 s_pos, fold, cordic_last, out_free;
	logic [31:0]          th_sum, th_f;
	logic signed [CW:0]   dr_full, di_full;
	logic signed [45:0]   sum_c;
	logic [59:0]          mm, mms;
	logic [31:0]          mag_c, per_c;
	logic [23:0]          step_c, step_abs;
	logic signed [48:0]   q_c;
	logic signed [49:0]   f_c;
	logic [49:0]          f_abs;
	logic                 f_small;

	// shared multiplier, registered
	always_comb begin
		mul_a = '0;
		mul_b = 33'(INV_GAIN);
		unique case (state_q)
			S_TH0: begin
				mul_a = 33'(t_q[31:0]);
				mul_b = 33'(inverse_period);
			end
			S_TH1: begin
				mul_a = 33'(t_q[47:32]);
				mul_b = 33'(inverse_period);
			end
			S_TH2:  mul_a = 33'(samp_q);
			S_G0: begin
				mul_a = 33'($signed(dr_q[41:24]));
				mul_b = 33'(smoothing_gain);
			end
			S_G1: begin
				mul_a = 33'(dr_q[23:0]);
				mul_b = 33'(smoothing_gain);
			end
			S_G2: begin
				mul_a = 33'($signed(di_q[41:24]));
				mul_b = 33'(smoothing_gain);
			end
			S_G3: begin
				mul_a = 33'(di_q[23:0]);
				mul_b = 33'(smoothing_gain);
			end
			S_M0:   mul_a = 33'(x_q[CW-1:32]);
			S_M1:   mul_a = 33'(x_q[31:0]);
			default: mul_a = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		mprod_q <= mul_a * mul_b;
	end

	// CORDIC micro-rotation, shared by rotation and vectoring
	always_comb begin
		sh_x  = x_q >>> i_q;
		sh_y  = y_q >>> i_q;
		at    = $signed({2'b0, atan_turns(5'(i_q))});
		s_pos = (state_q == S_ROT) ? !z_q[33] : y_q[CW-1];
		if (s_pos) begin
			nx = x_q - sh_y;
			ny = y_q + sh_x;
			nz = z_q - at;
		end else begin
			nx = x_q + sh_y;
			ny = y_q - sh_x;
			nz = z_q + at;
		end
		cordic_last = (i_q == IW'(CORDIC_STEPS - 1));
	end

	always_comb begin
		th_sum  = theta_q + 32'h4000_0000;
		fold    = th_sum[31];
		th_f    = fold ? (theta_q ^ 32'h8000_0000) : theta_q;
		xv      = mprod_q[CW-1:0];
		px      = x_q >>> PSH;
		py      = y_q >>> PSH;
		dr_full = (CW + 1)'(px) - (CW + 1)'(acc_re_q);
		di_full = (CW + 1)'(py) - (CW + 1)'(acc_im_q);
		sum_c   = 46'((state_q == S_G2) ? acc_re_q : acc_im_q) + 46'(gr_q)
			+ $signed({22'b0, mprod_q[47:24]});
		mm      = 60'(mh_q) + 60'(mprod_q[63:32]);
		mms     = mm >> MSH;
		mag_c   = (|mms[59:32]) ? 32'hFFFF_FFFF : mms[31:0];
		step_c  = (!first_q && prior_nz_q && nz_q) ? (phase_q - prior_phase_q) : '0;
		step_abs = step_c[23] ? (24'd0 - step_c) : step_c;
		q_c     = step_q[23] ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
		f_c     = $signed({2'b0, inverse_period, 16'b0}) - 50'(q_q);
		f_abs   = f_c[49] ? 50'(-f_c) : 50'(f_c);
		f_small = (f_abs <= 50'h1_0000_0000);
		if (fneg_q)
			per_c = (div_rsp.quot > 48'h8000_0000) ? PERIOD_MIN : (32'd0 - div_rsp.quot[31:0]);
		else
			per_c = (div_rsp.quot > 48'h7FFF_FFFF) ? PERIOD_MAX : div_rsp.quot[31:0];
	end

	// divider requests: step over duration, then two to the 64 over frequency
	always_comb begin
		div_req.start = ((state_q == S_STEP) && dur_pos_q)
			|| ((state_q == S_F) && (f_c != '0) && !f_small);
		if (state_q == S_STEP) begin
			div_req.rem_init = '0;
			div_req.dividend = {step_abs, 24'b0};
			div_req.divisor  = 50'(dur_q);
			div_req.steps    = DIV_Q_STEPS;
		end else begin
			div_req.rem_init = 51'h1_0000_0000;
			div_req.dividend = '0;
			div_req.divisor  = f_abs;
			div_req.steps    = DIV_P_STEPS;
		end
	end

	assign out_free      = !out_valid_q || m_tready;
	assign q_pop         = (state_q == S_IDLE) && !q_empty;
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = out_data_q;
	assign stat.idle     = (state_q == S_IDLE);
	assign stat.out_wait = (state_q == S_OUT) && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			t_q           <= '0;
			samp_q        <= '0;
			first_q       <= 1'b0;
			dur_pos_q     <= 1'b0;
			dur_q         <= '0;
			theta_q       <= '0;
			x_q           <= '0;
			y_q           <= '0;
			z_q           <= '0;
			i_q           <= '0;
			dr_q          <= '0;
			di_q          <= '0;
			gr_q          <= '0;
			acc_re_q      <= '0;
			acc_im_q      <= '0;
			mh_q          <= '0;
			mag_q         <= '0;
			phase_q       <= '0;
			nz_q          <= 1'b0;
			prior_phase_q <= '0;
			prior_nz_q    <= 1'b0;
			step_q        <= '0;
			q_q           <= '0;
			fneg_q        <= 1'b0;
			per_q         <= '0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
		end else begin
			if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						t_q       <= head_meta.t;
						samp_q    <= head_sample;
						first_q   <= head_meta.first;
						dur_pos_q <= head_meta.dur_pos;
						dur_q     <= head_meta.dur;
						state_q   <= S_TH0;
					end
				end
				S_TH0: state_q <= S_TH1;
				S_TH1: begin
					theta_q <= mprod_q[47:16];
					state_q <= S_TH2;
				end
				S_TH2: begin
					theta_q <= theta_q + {mprod_q[15:0], 16'b0};
					state_q <= S_X0;
				end
				S_X0: begin
					// fold the back half-plane onto the front one
					x_q     <= fold ? -xv : xv;
					y_q     <= '0;
					z_q     <= $signed({{2{th_f[31]}}, th_f});
					i_q     <= '0;
					state_q <= S_ROT;
				end
				S_ROT: begin
					x_q <= nx;
					y_q <= ny;
					z_q <= nz;
					i_q <= i_q + 1'b1;
					if (cordic_last)
						state_q <= S_SH;
				end
				S_SH: begin
					dr_q    <= dr_full[41:0];
					di_q    <= di_full[41:0];
					state_q <= S_G0;
				end
				S_G0: state_q <= S_G1;
				S_G1: begin
					gr_q    <= mprod_q[43:0];
					state_q <= S_G2;
				end
				S_G2: begin
					acc_re_q <= sat40(sum_c);
					state_q  <= S_G3;
				end
				S_G3: begin
					gr_q    <= mprod_q[43:0];
					state_q <= S_G4;
				end
				S_G4: begin
					acc_im_q <= sat40(sum_c);
					state_q  <= S_VEC0;
				end
				S_VEC0: begin
					i_q <= '0;
					if (acc_re_q == '0 && acc_im_q == '0) begin
						mag_q   <= '0;
						phase_q <= '0;
						nz_q    <= 1'b0;
						state_q <= S_STEP;
					end else begin
						x_q     <= acc_re_q[39] ? -CW'(acc_re_q) : CW'(acc_re_q);
						y_q     <= acc_re_q[39] ? -CW'(acc_im_q) : CW'(acc_im_q);
						z_q     <= acc_re_q[39] ? 34'sh0_8000_0000 : '0;
						state_q <= S_VEC;
					end
				end
				S_VEC: begin
					x_q <= nx;
					y_q <= ny;
					z_q <= nz;
					i_q <= i_q + 1'b1;
					if (cordic_last)
						state_q <= S_M0;
				end
				S_M0: state_q <= S_M1;
				S_M1: begin
					mh_q    <= mprod_q[58:0];
					state_q <= S_M2;
				end
				S_M2: begin
					mag_q   <= mag_c;
					phase_q <= z_q[31:8];
					nz_q    <= 1'b1;
					state_q <= S_STEP;
				end
				S_STEP: begin
					step_q        <= step_c;
					prior_phase_q <= phase_q;
					prior_nz_q    <= nz_q;
					if (dur_pos_q) begin
						state_q <= S_QDIV;
					end else begin
						q_q     <= '0;
						state_q <= S_F;
					end
				end
				S_QDIV: begin
					if (div_rsp.done) begin
						q_q     <= q_c;
						state_q <= S_F;
					end
				end
				S_F: begin
					fneg_q <= f_c[49];
					if (f_c == '0) begin
						per_q   <= PERIOD_MAX;
						state_q <= S_OUT;
					end else if (f_small) begin
						per_q   <= f_c[49] ? PERIOD_MIN : PERIOD_MAX;
						state_q <= S_OUT;
					end else begin
						state_q <= S_PDIV;
					end
				end
				S_PDIV: begin
					if (div_rsp.done) begin
						per_q   <= per_c;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {per_q, step_q, phase_q, mag_q};
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/phasor_period_tracker_top.sv =====
// Top level of the phasor period tracker: register file, front, queue, back and divider.
// Depends on ppt_pkg, ppt_front, ppt_fifo, ppt_div and ppt_back.
`timescale 1ns / 1ps
//
//  channel   direction  transaction         payload
//  s_*       in         one sample          s_tdata: sample_index, sample_value
//  m_*       out        one result          m_tdata: magnitude, phase_turns,
//                                           phase_step, tracked_period
//  APB       in         register access     inverse_period, phase_offset,
//                                           smoothing_gain at 0x0, 0x4, 0x8
//
//  In the back end an item goes through two CORDIC passes of one step a cycle (the
//  vectoring pass skipped when the smoothed phasor is zero), then the serial divider for
//  step over duration (skipped on the first sample or a non-positive duration) and for
//  the period (skipped when the frequency saturates). Reset clears the registers, the
//  smoother and all history at once. The front keeps taking samples into the queue
//  (QUEUE_DEPTH entries, two by default) while the back works or while a finished
//  result waits in the output register for m_tready.
module phasor_period_tracker_top #(
	parameter int SAMPLE_BITS  = ppt_pkg::SAMPLE_BITS_DEF,
	parameter int CORDIC_STEPS = ppt_pkg::CORDIC_STEPS_DEF,
	parameter int QUEUE_DEPTH  = ppt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,   // sample_index [31:0], sample_value [47:32]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // magnitude [31:0], phase_turns [55:32],
	                                // phase_step [79:56], tracked_period [111:80]
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import ppt_pkg::*;

	localparam int QW = SAMPLE_BITS + $bits(ppt_meta_t);

	logic [31:0] inv_period_q, phase_offset_q;
	logic [23:0] gain_q;
	logic        cfg_wr;

	logic                   push, pop, q_full, q_empty;
	logic [SAMPLE_BITS-1:0] push_sample;
	ppt_meta_t              push_meta, head_meta;
	logic [QW-1:0]          head;
	ppt_div_req_t           div_req;
	ppt_div_rsp_t           div_rsp;
	ppt_back_stat_t         stat;

	// register file: no wait states, write at the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_period_q   <= '0;
			phase_offset_q <= '0;
			gain_q         <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_INV_PERIOD:   inv_period_q   <= pwdata;
				REG_PHASE_OFFSET: phase_offset_q <= pwdata;
				REG_GAIN:         gain_q         <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_INV_PERIOD:   prdata = inv_period_q;
			REG_PHASE_OFFSET: prdata = phase_offset_q;
			REG_GAIN:         prdata = {8'b0, gain_q};
			default:          prdata = '0;
		endcase
	end

	// front: accept and classify
	ppt_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.phase_offset (phase_offset_q),
		.q_full       (q_full),
		.push         (push),
		.push_sample  (push_sample),
		.push_meta    (push_meta)
	);

	// queue decouples acceptance from the long back-end sequence
	ppt_fifo #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_sample, push_meta}),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	assign head_meta = head[$bits(ppt_meta_t)-1:0];

	ppt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// back: mix, smooth, vector, step and period
	ppt_back #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.head_sample    (head[QW-1:$bits(ppt_meta_t)]),
		.head_meta      (head_meta),
		.q_pop          (pop),
		.inverse_period (inv_period_q),
		.smoothing_gain (gain_q),
		.div_req        (div_req),
		.div_rsp        (div_rsp),
		.stat           (stat),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata)
	);

	// never restart the divider in the middle of a division
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// an accepted sample is held in the queue at the next edge
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !q_empty)
		else $error("accepted sample missing from queue");

	// an idle back end picks up a waiting item straight away
	a_back_picks_up: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.idle && !q_empty) |=> !stat.idle)
		else $error("back end left a queued item waiting");

	// done and busy never overlap
	a_div_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> !div_rsp.busy)
		else $error("divider done while busy");
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for phasor_period_tracker_top: directed and random samples.
// Depends on ppt_pkg for register indexes; predicts each result with its own model.
`timescale 1ns / 1ps
module testbench;
	import ppt_pkg::*;

	typedef struct {
		logic [31:0] magnitude;
		logic [23:0] phase_turns;
		logic [23:0] phase_step;
		logic [31:0] tracked_period;
	} tracker_result_t;

	localparam longint ACC_LIMIT = 64'sd549755813887;
	localparam longint unsigned UNITY_GAIN = 64'd2608131497;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [47:0]  s_tdata = '0;   // sample_index [31:0], sample_value [47:32]
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;        // magnitude [31:0], phase_turns [55:32],
	                              // phase_step [79:56], tracked_period [111:80]
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	// predictor copy of the registers and history
	logic [31:0] cfg_inv_period, cfg_offset;
	logic [23:0] cfg_gain;
	longint      sm_real, sm_imag;
	logic [23:0] last_phase;
	logic        last_nonzero, have_first;
	logic [31:0] last_index;

	logic [31:0] arctan_tab [0:31];
	tracker_result_t pending_results [$];
	int          fail_count = 0;
	int          result_count = 0;
	int          burst_left = 0;
	int          hold_request = 0;
	int          hold_left = 0;
	int          stall_phase = 0;
	logic [31:0] walk_index = 0;

	phasor_period_tracker_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	initial begin
		arctan_tab = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
			32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163,
			32'd1335087, 32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
			32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326,
			32'd163, 32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
	end

	function automatic longint gain_scale(longint d, logic [23:0] g);
		longint hi, lo;
		hi = d >>> 24;
		lo = d - hi * 64'sd16777216;
		return hi * longint'({40'd0, g}) + ((lo * longint'({40'd0, g})) >>> 24);
	endfunction

	function automatic longint clamp40(longint v);
		if (v > ACC_LIMIT)
			return ACC_LIMIT;
		if (v < -ACC_LIMIT - 1)
			return -ACC_LIMIT - 1;
		return v;
	endfunction

	// Work out the result of one sample and advance the predictor history.
	function automatic tracker_result_t track_sample(logic [31:0] idx, logic [15:0] val);
		tracker_result_t r;
		longint unsigned t, m, a, q64;
		longint x, y, z, nx, px, py, step, dur, quo, f, per;
		logic [31:0] theta, fold, ang;
		logic [23:0] phase;
		logic nonzero, neg;
		int i;
		t = ({32'd0, idx} << 16) + longint'($signed(cfg_offset));
		t = t * {32'd0, cfg_inv_period};
		theta = t[47:16];
		x = longint'($signed(val)) * longint'(UNITY_GAIN);
		y = 0;
		fold = theta + 32'h4000_0000;
		if (fold[31]) begin
			x = -x;
			theta = theta - 32'h8000_0000;
		end
		z = longint'($signed(theta));
		for (i = 0; i < 24; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - longint'({32'd0, arctan_tab[i]});
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + longint'({32'd0, arctan_tab[i]});
			end
			x = nx;
		end
		px = x >>> 8;
		py = y >>> 8;
		sm_real = clamp40(sm_real + gain_scale(px - sm_real, cfg_gain));
		sm_imag = clamp40(sm_imag + gain_scale(py - sm_imag, cfg_gain));

		x = sm_real;
		y = sm_imag;
		ang = 0;
		r.magnitude = 0;
		if (x != 0 || y != 0) begin
			if (x < 0) begin
				x = -x;
				y = -y;
				ang = 32'h8000_0000;
			end
			for (i = 0; i < 24; i++) begin
				if (y >= 0) begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					ang = ang + arctan_tab[i];
				end else begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					ang = ang - arctan_tab[i];
				end
				x = nx;
			end
			m = x;
			m = (m >> 32) * UNITY_GAIN + (((m & 64'hFFFF_FFFF) * UNITY_GAIN) >> 32);
			m = m >> 8;
			r.magnitude = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
		end
		phase = ang[31:8];
		nonzero = (sm_real != 0) || (sm_imag != 0);

		step = 0;
		dur = 0;
		if (have_first) begin
			dur = longint'({32'd0, idx}) - longint'({32'd0, last_index});
			if (last_nonzero && nonzero)
				step = longint'($signed(phase - last_phase));
		end
		quo = (dur > 0) ? (step * 64'sd16777216) / dur : 0;
		f = longint'({16'd0, cfg_inv_period, 16'd0}) - quo;
		if (f == 0) begin
			per = 64'sh7FFF_FFFF;
		end else begin
			neg = f < 0;
			a = neg ? -f : f;
			if (a <= 64'h1_0000_0000) begin
				per = neg ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
			end else begin
				q64 = 64'hFFFF_FFFF_FFFF_FFFF / a;
				if (64'hFFFF_FFFF_FFFF_FFFF % a == a - 1)
					q64++;
				if (neg)
					per = (q64 > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(q64);
				else
					per = (q64 > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q64);
			end
		end

		last_phase = phase;
		last_nonzero = nonzero;
		last_index = idx;
		have_first = 1'b1;
		r.phase_turns = phase;
		r.phase_step = step[23:0];
		r.tracked_period = per[31:0];
		return r;
	endfunction

	// Offer one sample; gaps between bursts fall before the offer.
	task automatic send_sample(logic [31:0] idx, logic [15:0] val);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
			if (gap > 0) begin
				@(negedge clk) s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {val, idx};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(track_sample(idx, val));
	endtask

	// Drop valid, wait for every result, then let the back end settle.
	task automatic drain;
		@(negedge clk) s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] reg_idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (reg_idx)
			REG_INV_PERIOD:   cfg_inv_period = value;
			REG_PHASE_OFFSET: cfg_offset = value;
			REG_GAIN:         cfg_gain = value[23:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(logic [31:0] ip, logic [31:0] off, logic [23:0] g);
		write_reg(REG_INV_PERIOD, ip);
		write_reg(REG_PHASE_OFFSET, off);
		write_reg(REG_GAIN, {8'd0, g});
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom());
		endcase
	endfunction

	// Mostly steady time steps, with repeats, reversals and jumps mixed in.
	function automatic logic [31:0] pick_index();
		case ($urandom_range(0, 19))
			0: walk_index = walk_index;
			1: walk_index = walk_index - $urandom_range(1, 1000);
			2: walk_index = $urandom();
			3: walk_index = walk_index + $urandom_range(100, 100000);
			default: walk_index = walk_index + $urandom_range(1, 4);
		endcase
		return walk_index;
	endfunction

	// Reset registers are all zero: the smoother never moves and the period saturates.
	task automatic test_reset_state;
		send_sample(32'd0, 16'h7FFF);
		send_sample(32'd1, 16'h8000);
		drain();
	endtask

	task automatic test_field_extremes;
		configure(32'h0100_0000, 32'h0000_0000, 24'hFF_FFFF);
		send_sample(32'd0, 16'h7FFF);
		send_sample(32'd1, 16'h8000);
		send_sample(32'd1, 16'h7FFF);            // zero duration
		send_sample(32'd0, 16'h0001);            // negative duration
		send_sample(32'hFFFF_FFFF, 16'hFFFF);
		send_sample(32'h0000_0000, 16'h0000);
		send_sample(32'h5555_5555, 16'h5555);
		send_sample(32'hAAAA_AAAA, 16'hAAAA);
		drain();
	endtask

	// Mixer angle of exactly one half turn, then an all-ones inverse period.
	task automatic test_half_turn;
		configure(32'h8000_0000, 32'h0000_0000, 24'h80_0000);
		send_sample(32'd1, 16'h4000);
		send_sample(32'd3, 16'hC000);
		send_sample(32'd5, 16'h4000);
		drain();
		configure(32'hFFFF_FFFF, 32'h8000_0000, 24'h00_0001);
		send_sample(32'd7, 16'h7FFF);
		send_sample(32'd8, 16'h7FFF);
		drain();
		write_reg(REG_PHASE_OFFSET, 32'h7FFF_FFFF);
		send_sample(32'd9, 16'h8000);
		drain();
	endtask

	// Zero gain freezes the smoothed phasor; zero frequency saturates the period.
	task automatic test_zero_gain;
		configure(32'h0000_0000, 32'h0001_0000, 24'h00_0000);
		send_sample(32'd10, 16'h7FFF);
		send_sample(32'd11, 16'h8000);
		drain();
	endtask

	task automatic test_random_phase(logic [31:0] ip, logic [31:0] off, logic [23:0] g,
			int count);
		int n;
		configure(ip, off, g);
		for (n = 0; n < count; n++)
			send_sample(pick_index(), pick_value());
		drain();
	endtask

	// Hold the result side for a long stretch while samples keep coming.
	task automatic test_output_hold;
		int n;
		configure($urandom(), $urandom(), 24'($urandom_range(1, 24'hFF_FFFF)));
		hold_request = 3000;
		burst_left = 100;
		for (n = 0; n < 20; n++)
			send_sample(pick_index(), pick_value());
		drain();
	endtask

	// Receiver: alternate stretches of free flow and random stalls.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		stall_phase = (stall_phase + 1) % 1400;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_phase < 500) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 2) != 0);
		end
	end

	// Compare every delivered result with the oldest prediction.
	always @(posedge clk) begin
		tracker_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			result_count++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				if (m_tdata[31:0] !== e.magnitude) begin
					$display("%0t: magnitude expected %h actual %h", $time,
						e.magnitude, m_tdata[31:0]);
					fail_count++;
				end
				if (m_tdata[55:32] !== e.phase_turns) begin
					$display("%0t: phase_turns expected %h actual %h", $time,
						e.phase_turns, m_tdata[55:32]);
					fail_count++;
				end
				if (m_tdata[79:56] !== e.phase_step) begin
					$display("%0t: phase_step expected %h actual %h", $time,
						e.phase_step, m_tdata[79:56]);
					fail_count++;
				end
				if (m_tdata[111:80] !== e.tracked_period) begin
					$display("%0t: tracked_period expected %h actual %h", $time,
						e.tracked_period, m_tdata[111:80]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		cfg_inv_period = 0;
		cfg_offset = 0;
		cfg_gain = 0;
		sm_real = 0;
		sm_imag = 0;
		last_phase = 0;
		last_nonzero = 1'b0;
		have_first = 1'b0;
		last_index = 0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_reset_state();
		test_field_extremes();
		test_half_turn();
		test_zero_gain();
		test_random_phase(32'h0147_AE14, 32'h0000_8000, 24'h02_0000, 300);
		test_random_phase(32'hFFFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 300);
		test_random_phase(32'h0000_0001, 32'h7FFF_FFFF, 24'h00_0001, 300);
		test_random_phase($urandom(), $urandom(), 24'($urandom()), 300);
		test_random_phase($urandom(), $urandom(), 24'($urandom()), 300);
		test_random_phase(32'h0000_0000, $urandom(), 24'($urandom()), 300);
		test_output_hold();

		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			fail_count++;
		end
		$display("Checked %0d results over zero, extreme and random register settings,", result_count);
		$display("with half turns, repeated and reversed times, bursty input and stalled output.");
		if (fail_count == 0)
			$display("PASS phasor_period_tracker_top");
		else
			$display("FAIL phasor_period_tracker_top");
		$finish;
	end

	initial begin
		#50ms;
		$display("Timeout: %0d results outstanding", pending_results.size());
		$display("FAIL phasor_period_tracker_top");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/ppt_pkg.sv
hdl/ppt_fifo.sv
hdl/ppt_front.sv
hdl/ppt_div.sv
hdl/ppt_back.sv
hdl/phasor_period_tracker_top.sv
tb/testbench.sv
